FILE: hw/rtl/trre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package trre_pkg;

  localparam int unsigned MAX_ROW_WIDTH_DEF = 4096;
  localparam int unsigned CFG_W             = 13;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 13'd256;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned WORD_W = 64;

  localparam int unsigned RUN_MAX = 127;
  localparam int unsigned LEN_W   = 7;
  localparam logic [LEN_W-1:0] RUN_LIMIT = 7'h7f;
  localparam logic [PIX_W-1:0] MARK      = 8'h80;

  localparam int unsigned CMD_DEPTH = 4;

  typedef logic [LEN_W-1:0] len_t;

  // One request's worth of encoding work, as handed from the front to the back.
  typedef struct packed {
    logic close_vld;
    logic close_tr;
    len_t close_len;
    logic close_bank;
    logic row_end;
    logic end_lit;
    len_t end_len;
    logic end_bank;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       en;
    len_t             addr;
    logic [PIX_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [1:0] en;
    len_t       addr;
  } ram_rd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHDR,
    BK_CDATA,
    BK_EHDR,
    BK_EDATA,
    BK_MARK
  } bk_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/trre_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface trre_pixel_if import trre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/trre_word_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface trre_word_if import trre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_bytes;

  modport source(output valid, output out_bytes, input ready);
  modport sink(input valid, input out_bytes, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/trre_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module trre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 127
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trre_front.sv
`timescale 1ns / 1ps
`default_nettype none
module trre_front import trre_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  trre_pixel_if.sink            in_pix,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  wire logic [1:0]       busy_clr,
  output ram_wr_t               ram_wr
);

  localparam int unsigned CW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_ROW_WIDTH);

  logic [CFG_W-1:0] row_width_r;
  logic [CW-1:0]    column_r, column_nxt;
  logic             run_active_r, run_active_nxt;
  logic             run_tr_r, run_tr_nxt;
  len_t             run_len_r, run_len_nxt;
  logic             cur_r, cur_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic [EW-1:0] width_ext, eff;
  logic [CW-1:0] col_inc;
  logic          lit_open, ready, accept, tr, close, cur_a, cont, row_end;
  len_t          base, len_new;
  logic [1:0]    busy_set;

  always_comb begin
    width_ext = EW'(row_width_r);
    if (width_ext == '0) begin
      eff = EW'(1);
    end else if (width_ext > MAX_W) begin
      eff = MAX_W;
    end else begin
      eff = width_ext;
    end
  end

  // A new literal run may not start in a bank whose earlier run is still being drained.
  assign lit_open     = run_active_r && !run_tr_r;
  assign ready        = !q_full && !busy_r[cur_r] && !(lit_open && busy_r[!cur_r]);
  assign in_pix.ready = ready;
  assign accept       = in_pix.valid && ready;

  assign tr      = (in_pix.pixel == '0);
  assign close   = run_active_r && ((tr != run_tr_r) || (run_len_r == RUN_LIMIT));
  assign cur_a   = cur_r ^ (close && !run_tr_r);
  assign cont    = run_active_r && !close;
  assign base    = cont ? run_len_r : '0;
  assign len_new = base + len_t'(1);
  assign col_inc = column_r + CW'(1);
  assign row_end = (EW'(col_inc) >= eff);

  always_comb begin
    column_nxt     = column_r;
    run_active_nxt = run_active_r;
    run_tr_nxt     = run_tr_r;
    run_len_nxt    = run_len_r;
    cur_nxt        = cur_r;
    busy_set       = '0;
    if (accept) begin
      column_nxt     = row_end ? '0 : col_inc;
      run_active_nxt = !row_end;
      run_tr_nxt     = tr;
      run_len_nxt    = row_end ? '0 : len_new;
      cur_nxt        = cur_a ^ (row_end && !tr);
      if (close && !run_tr_r) begin
        busy_set[cur_r] = 1'b1;
      end
      if (row_end && !tr) begin
        busy_set[cur_a] = 1'b1;
      end
    end
    busy_nxt = (busy_r & ~busy_clr) | busy_set;
  end

  always_comb begin
    q_push           = accept && (close || row_end);
    q_cmd.close_vld  = close;
    q_cmd.close_tr   = run_tr_r;
    q_cmd.close_len  = run_len_r;
    q_cmd.close_bank = cur_r;
    q_cmd.row_end    = row_end;
    q_cmd.end_lit    = row_end && !tr;
    q_cmd.end_len    = len_new;
    q_cmd.end_bank   = cur_a;

    ram_wr.en        = '0;
    ram_wr.en[cur_a] = accept && !tr;
    ram_wr.addr      = base;
    ram_wr.data      = in_pix.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r  <= ROW_WIDTH_RST;
      column_r     <= '0;
      run_active_r <= 1'b0;
      run_tr_r     <= 1'b0;
      run_len_r    <= '0;
      cur_r        <= 1'b0;
      busy_r       <= '0;
    end else begin
      if (cfg_we) begin
        row_width_r <= cfg_wdata;
      end
      column_r     <= column_nxt;
      run_active_r <= run_active_nxt;
      run_tr_r     <= run_tr_nxt;
      run_len_r    <= run_len_nxt;
      cur_r        <= cur_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trre_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module trre_cmd_fifo import trre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_vld,
  output cmd_t      head_cmd
);

  localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_r [CMD_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == NW'(CMD_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trre_back.sv
`timescale 1ns / 1ps
`default_nettype none
module trre_back import trre_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmd_vld,
  input  wire cmd_t                  cmd_in,
  output logic                       cmd_pop,
  output ram_rd_t                    ram_rd,
  input  wire logic [1:0][PIX_W-1:0] rd_data,
  output logic      [1:0]            busy_clr,
  trre_word_if.source                out_word
);

  bk_state_t state_r, state_nxt, after_close;
  cmd_t      cmd_r;
  len_t      idx_r, idx_nxt;

  logic             a_emit, a_ram, a_bank, a_last;
  logic [PIX_W-1:0] a_byte;
  logic             c_last, e_last;

  logic             b_vld_r, b_ram_r, b_bank_r, b_last_r;
  logic [PIX_W-1:0] b_byte_r, b_val;
  logic             b_free, b_take, complete, out_free;

  logic [WORD_W-1:0] acc_r, word;
  logic [2:0]        cnt_r;
  logic              out_vld_r;
  logic [WORD_W-1:0] out_data_r;

  assign c_last      = (idx_r == cmd_r.close_len - len_t'(1));
  assign e_last      = (idx_r == cmd_r.end_len - len_t'(1));
  assign after_close = cmd_r.end_lit ? BK_EHDR : BK_MARK;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_vld) begin
          if (cmd_in.close_vld) begin
            state_nxt = BK_CHDR;
          end else begin
            state_nxt = cmd_in.end_lit ? BK_EHDR : BK_MARK;
          end
        end
      end
      BK_CHDR: begin
        if (b_free) begin
          if (!cmd_r.close_tr) begin
            state_nxt = BK_CDATA;
          end else begin
            state_nxt = cmd_r.row_end ? after_close : BK_IDLE;
          end
        end
      end
      BK_CDATA: begin
        if (b_free && c_last) begin
          state_nxt = cmd_r.row_end ? after_close : BK_IDLE;
        end
      end
      BK_EHDR: begin
        if (b_free) begin
          state_nxt = BK_EDATA;
        end
      end
      BK_EDATA: begin
        if (b_free && e_last) begin
          state_nxt = BK_MARK;
        end
      end
      BK_MARK: begin
        if (b_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    a_emit      = 1'b0;
    a_ram       = 1'b0;
    a_bank      = 1'b0;
    a_last      = 1'b0;
    a_byte      = '0;
    ram_rd.en   = '0;
    ram_rd.addr = idx_r;
    busy_clr    = '0;
    idx_nxt     = idx_r;
    case (state_r)
      BK_IDLE: begin
        cmd_pop = cmd_vld;
      end
      BK_CHDR: begin
        a_emit = 1'b1;
        a_byte = cmd_r.close_tr ? (MARK | PIX_W'(cmd_r.close_len)) : PIX_W'(cmd_r.close_len);
        a_last = cmd_r.close_tr && !cmd_r.row_end;
      end
      BK_CDATA: begin
        a_emit                     = 1'b1;
        a_ram                      = 1'b1;
        a_bank                     = cmd_r.close_bank;
        a_last                     = c_last && !cmd_r.row_end;
        ram_rd.en[cmd_r.close_bank] = b_free;
        busy_clr[cmd_r.close_bank]  = b_free && c_last;
        if (b_free) begin
          idx_nxt = c_last ? '0 : idx_r + len_t'(1);
        end
      end
      BK_EHDR: begin
        a_emit = 1'b1;
        a_byte = PIX_W'(cmd_r.end_len);
      end
      BK_EDATA: begin
        a_emit                    = 1'b1;
        a_ram                     = 1'b1;
        a_bank                    = cmd_r.end_bank;
        ram_rd.en[cmd_r.end_bank] = b_free;
        busy_clr[cmd_r.end_bank]  = b_free && e_last;
        if (b_free) begin
          idx_nxt = e_last ? '0 : idx_r + len_t'(1);
        end
      end
      BK_MARK: begin
        a_emit = 1'b1;
        a_byte = MARK;
        a_last = 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // The byte stage holds a store byte by keeping the read enable low while it waits.
  assign b_val    = b_ram_r ? rd_data[b_bank_r] : b_byte_r;
  assign out_free = !out_vld_r || out_word.ready;
  assign complete = b_last_r || (cnt_r == 3'd7);
  assign b_take   = b_vld_r && (!complete || out_free);
  assign b_free   = !b_vld_r || b_take;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word[8*i +: 8] = (cnt_r == 3'(i)) ? b_val : acc_r[8*i +: 8];
    end
  end

  assign out_word.valid     = out_vld_r;
  assign out_word.out_bytes = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_in;
    end
    if (b_free && a_emit) begin
      b_ram_r  <= a_ram;
      b_bank_r <= a_bank;
      b_byte_r <= a_byte;
      b_last_r <= a_last;
    end
    if (b_take && complete) begin
      out_data_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      idx_r     <= '0;
      b_vld_r   <= 1'b0;
      acc_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (b_free) begin
        b_vld_r <= a_emit;
      end
      if (b_take) begin
        if (complete) begin
          acc_r <= '0;
          cnt_r <= '0;
        end else begin
          acc_r <= word;
          cnt_r <= cnt_r + 3'd1;
        end
      end
      if (b_take && complete) begin
        out_vld_r <= 1'b1;
      end else if (out_word.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/transparent_rle_row_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// With an idle drain, a request's first word is valid once the pixel closing it has passed the
// request queue, the drain's command register, its byte stage and the output word register.
// Throughput: one pixel per cycle; a closed literal run holds the drain for its header and data bytes.
// Pixels stall while the request queue is full, the current literal bank is still draining, or a
// literal run is open while the other bank drains. The drain packs one byte per cycle while the output is free.
// Synchronous active-low reset clears the row and run state and sets the row width to 256.
module transparent_rle_row_encoder import trre_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  trre_pixel_if.sink            in_pix,
  trre_word_if.source           out_word
);

  logic                  q_push, q_full, q_pop, q_vld;
  cmd_t                  q_cmd, q_head;
  logic [1:0]            busy_clr;
  ram_wr_t               ram_wr;
  ram_rd_t               ram_rd;
  logic [1:0][PIX_W-1:0] rd_data;

  trre_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_pix   (in_pix),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .busy_clr (busy_clr),
    .ram_wr   (ram_wr)
  );

  trre_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .head_vld(q_vld),
    .head_cmd(q_head)
  );

  for (genvar b = 0; b < 2; b++) begin : g_bank
    trre_ram #(
      .WIDTH(PIX_W),
      .DEPTH(RUN_MAX)
    ) u_ram (
      .clk  (clk),
      .we   (ram_wr.en[b]),
      .waddr(ram_wr.addr),
      .wdata(ram_wr.data),
      .re   (ram_rd.en[b]),
      .raddr(ram_rd.addr),
      .rdata(rd_data[b])
    );
  end

  trre_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (q_vld),
    .cmd_in  (q_head),
    .cmd_pop (q_pop),
    .ram_rd  (ram_rd),
    .rd_data (rd_data),
    .busy_clr(busy_clr),
    .out_word(out_word)
  );

endmodule
`default_nettype wire

FILE: test/tb_transparent_rle_row_encoder.sv
`timescale 1ns / 1ps
module tb_transparent_rle_row_encoder;
  import trre_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  trre_pixel_if in_pix();
  trre_word_if  out_word();

  transparent_rle_row_encoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_pix   (in_pix.sink),
    .out_word (out_word.source)
  );

  logic [CFG_W-1:0]  row_width_m;
  int unsigned       column_m;
  bit                run_open_m;
  bit                run_clear_m;
  int unsigned       run_len_m;
  logic [PIX_W-1:0]  literal_m [RUN_MAX];
  logic [PIX_W-1:0]  encoded_bytes [$];
  logic [WORD_W-1:0] expected_words [$];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  int errors;
  int pixels_sent;
  int words_checked;
  int width_writes;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic void push_literal_run();
    encoded_bytes.push_back(PIX_W'(run_len_m));
    for (int i = 0; i < run_len_m; i++) begin
      encoded_bytes.push_back(literal_m[i]);
    end
  endfunction

  // Each accepted pixel is folded into the expected words at once.
  function automatic void encode_pixel(input logic [PIX_W-1:0] px);
    int unsigned   eff_width;
    bit            clear;
    logic [WORD_W-1:0] w;
    eff_width = row_width_m;
    if (eff_width == 0) eff_width = 1;
    if (eff_width > MAX_ROW_WIDTH_DEF) eff_width = MAX_ROW_WIDTH_DEF;
    clear = (px == '0);
    encoded_bytes.delete();
    if (run_open_m && (clear != run_clear_m || run_len_m >= RUN_MAX)) begin
      if (run_clear_m) begin
        encoded_bytes.push_back(MARK + PIX_W'(run_len_m));
      end else begin
        push_literal_run();
      end
      run_open_m = 1'b0;
      run_len_m  = 0;
    end
    if (!run_open_m) begin
      run_open_m  = 1'b1;
      run_clear_m = clear;
      run_len_m   = 0;
    end
    if (!clear && run_len_m < RUN_MAX) literal_m[run_len_m] = px;
    run_len_m++;
    column_m++;
    if (column_m >= eff_width) begin
      if (!run_clear_m) push_literal_run();
      encoded_bytes.push_back(MARK);
      column_m   = 0;
      run_open_m = 1'b0;
      run_len_m  = 0;
    end
    for (int k = 0; k < encoded_bytes.size(); k += 8) begin
      w = '0;
      for (int j = 0; j < 8; j++) begin
        if (k + j < encoded_bytes.size()) w[8*j +: 8] = encoded_bytes[k + j];
      end
      expected_words.push_back(w);
    end
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(negedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.pixel <= px;
    do @(posedge clk); while (!in_pix.ready);
    encode_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_run(input bit clear, input int len);
    for (int i = 0; i < len; i++) begin
      send_pixel(clear ? 8'h00 : PIX_W'($urandom_range(1, 255)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_pix.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    row_width_m = value;
    width_writes++;
  endtask

  task automatic test_directed();
    logic [PIX_W-1:0] row_a [6] = '{8'h00, 8'h00, 8'hff, 8'h01, 8'h00, 8'h00};
    logic [PIX_W-1:0] row_b [6] = '{8'h80, 8'h7f, 8'h00, 8'h05, 8'h55, 8'haa};
    send_idle_pct = 38;
    recv_idle_pct = 47;
    write_row_width(13'd6);
    foreach (row_a[i]) send_pixel(row_a[i]);
    foreach (row_b[i]) send_pixel(row_b[i]);
    send_run(1'b1, 6);
    write_row_width(13'd0);
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h07);
    write_row_width(13'h1fff);
    send_pixel(8'h09);
    send_pixel(8'h00);
    send_pixel(8'h00);
    // Shrinking the width below the column already reached closes the row on the next pixel.
    write_row_width(13'd2);
    send_pixel(8'h11);
  endtask

  task automatic test_run_limit();
    send_idle_pct = 47;
    recv_idle_pct = 38;
    write_row_width(13'd4096);
    send_run(1'b1, 128);
    send_run(1'b0, 130);
    send_run(1'b1, 3);
    write_row_width(13'd1);
    send_pixel(8'h33);
    send_pixel(8'h00);
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int n_items);
    int target;
    int budget;
    int pick;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = pixels_sent + n_items;
    while (pixels_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) write_row_width(CFG_W'($urandom_range(1, 16)));
      else if (pick < 85) write_row_width(CFG_W'($urandom_range(17, 160)));
      else if (pick < 92) write_row_width('0);
      else if (pick < 96) write_row_width(CFG_W'(MAX_ROW_WIDTH_DEF));
      else write_row_width(CFG_W'($urandom_range(4097, 8191)));
      budget = pixels_sent + $urandom_range(20, 60);
      while (pixels_sent < budget && pixels_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 60);
        else len = $urandom_range(120, 135);
        if (len > target - pixels_sent) len = target - pixels_sent;
        send_run(1'($urandom_range(1)), len);
      end
    end
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_row_width(13'd3);
    stall_cycles = 300;
    for (int i = 0; i < 30; i++) begin
      send_pixel(($urandom_range(2) == 0) ? 8'h00 : PIX_W'($urandom_range(1, 255)));
    end
  endtask

  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_word.ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_word.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %h", $time,
                 out_word.out_bytes);
        errors++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_word.out_bytes !== want) begin
          $display("%0t: output word mismatch, expected %h, got %h", $time, want,
                   out_word.out_bytes);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_pix.valid   = 1'b0;
    in_pix.pixel   = '0;
    out_word.ready = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_cycles   = 0;
    errors         = 0;
    pixels_sent    = 0;
    words_checked  = 0;
    width_writes   = 0;
    row_width_m    = ROW_WIDTH_RST;
    column_m       = 0;
    run_open_m     = 1'b0;
    run_clear_m    = 1'b0;
    run_len_m      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_run_limit();
    test_random(38, 47, 15);
    test_random(47, 38, 15);
    test_random(0, 0, 15);
    test_output_stall();

    wait_drained();
    if (expected_words.size() != 0) errors++;
    $display("Run covered %0d pixels under %0d row width settings and %0d checked words,",
             pixels_sent, width_writes, words_checked);
    $display("including runs past the length limit, mid-row width changes and a long output stall.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/trre_pkg.sv
hw/rtl/trre_pixel_if.sv
hw/rtl/trre_word_if.sv
hw/rtl/trre_ram.sv
hw/rtl/trre_front.sv
hw/rtl/trre_cmd_fifo.sv
hw/rtl/trre_back.sv
hw/rtl/transparent_rle_row_encoder.sv
test/tb_transparent_rle_row_encoder.sv
